// ===== hdl/room_mode_frequency_evaluator_unit_defines.svh =====
// Assertion macros shared by the room mode frequency evaluator RTL.
// Depends on each using module having ports named i_clk and i_rst_n.
`ifndef ROOM_MODE_FREQUENCY_EVALUATOR_UNIT_DEFINES_SVH
`define ROOM_MODE_FREQUENCY_EVALUATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RMFE_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication after a fixed number of cycles, checked outside reset.
`define RMFE_ASSERT_DELAY(label, ante, n, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##(n) (cons)) \
        else $error(msg);

`endif

// ===== hdl/rmfe_pkg.sv =====
// Package for the room mode frequency evaluator: widths, pipeline depths,
// register indexes and the sideband type. No dependencies.
`default_nettype none

package rmfe_pkg;

    localparam int ORDER_W    = 10;
    localparam int STEP_W     = 24;
    localparam int FREQ_W     = 34;
    localparam int KIND_W     = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 34;

    localparam logic [ORDER_W-1:0] ORDER_MAX = 10'd512;

    // order * step is exact in PROD_W bits; its square in SQ_W bits.
    localparam int PROD_W = ORDER_W + STEP_W;
    localparam int HALF_W = PROD_W / 2;
    localparam int PP_W   = 2 * HALF_W;
    localparam int SQ_W   = 2 * PROD_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int ROOT_W = SUM_W / 2;

    // Product, partial products, square assembly, sum of squares.
    localparam int PRE_STG  = 4;
    localparam int SQRT_STG = ROOT_W;
    localparam int PIPE_LAT = PRE_STG + SQRT_STG + 1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_STEP_X     = 2'd0,
        CFG_STEP_Y     = 2'd1,
        CFG_STEP_Z     = 2'd2,
        CFG_BAND_LIMIT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              order_ok;
    } t_side;

endpackage

`default_nettype wire

// ===== hdl/rmfe_square.sv =====
// Two-stage squarer for one order*step product, built from 17x17 partial products.
// Depends on rmfe_pkg.
`default_nettype none

module rmfe_square
    import rmfe_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic [PROD_W-1:0] i_val,
    output logic      [SQ_W-1:0]   o_sq
);

    logic [HALF_W-1:0] w_h;
    logic [HALF_W-1:0] w_l;
    logic [PP_W-1:0]   n_hh;
    logic [PP_W-1:0]   n_hl;
    logic [PP_W-1:0]   n_ll;
    logic [PP_W-1:0]   r_hh;
    logic [PP_W-1:0]   r_hl;
    logic [PP_W-1:0]   r_ll;
    logic [SQ_W-1:0]   n_sq;
    logic [SQ_W-1:0]   r_sq;

    assign w_h = i_val[PROD_W-1:HALF_W];
    assign w_l = i_val[HALF_W-1:0];

    assign n_hh = {{HALF_W{1'b0}}, w_h} * {{HALF_W{1'b0}}, w_h};
    assign n_hl = {{HALF_W{1'b0}}, w_h} * {{HALF_W{1'b0}}, w_l};
    assign n_ll = {{HALF_W{1'b0}}, w_l} * {{HALF_W{1'b0}}, w_l};

    // h*h sits fully above l*l, so the two simply concatenate; the doubled
    // cross term lands HALF_W+1 bits up.
    assign n_sq = {r_hh, r_ll} + SQ_W'({r_hl, {(HALF_W+1){1'b0}}});

    always_ff @(posedge i_clk) begin
        r_hh <= n_hh;
        r_hl <= n_hl;
        r_ll <= n_ll;
        r_sq <= n_sq;
    end

    assign o_sq = r_sq;

endmodule

`default_nettype wire

// ===== hdl/rmfe_isqrt.sv =====
// Pipelined floor square root, one result bit per stage, with a sideband
// carried alongside. Depends on rmfe_pkg and the assertion macro header.
`default_nettype none

`include "room_mode_frequency_evaluator_unit_defines.svh"

module rmfe_isqrt
    import rmfe_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire t_side             i_side,
    input  wire logic [SUM_W-1:0]  i_rad,
    output logic                   o_valid,
    output t_side                  o_side,
    output logic      [ROOT_W-1:0] o_root
);

    logic              r_valid [SQRT_STG];
    t_side             r_side  [SQRT_STG];
    logic [SUM_W-1:0]  r_rem   [SQRT_STG];
    logic [ROOT_W-1:0] r_root  [SQRT_STG];

    for (genvar k = 0; k < SQRT_STG; k++) begin : g_stage
        localparam int BIT = ROOT_W - 1 - k;

        logic              w_valid;
        t_side             w_side;
        logic [SUM_W-1:0]  w_rem;
        logic [ROOT_W-1:0] w_root;
        logic [SUM_W-1:0]  w_trial;
        logic              w_take;
        logic [SUM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;

        if (k == 0) begin : g_first
            assign w_valid = i_valid;
            assign w_side  = i_side;
            assign w_rem   = i_rad;
            assign w_root  = '0;
        end else begin : g_next
            assign w_valid = r_valid[k-1];
            assign w_side  = r_side[k-1];
            assign w_rem   = r_rem[k-1];
            assign w_root  = r_root[k-1];
        end

        // Setting this bit adds 2*root*2^BIT + 2^(2*BIT) to the square.
        assign w_trial = (SUM_W'(w_root) << (BIT + 1)) | (SUM_W'(1) << (2 * BIT));
        assign w_take  = (w_rem >= w_trial);
        assign n_rem   = w_take ? (w_rem - w_trial) : w_rem;
        assign n_root  = w_take ? (w_root | (ROOT_W'(1) << BIT)) : w_root;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= w_valid;
            end
            r_side[k] <= w_side;
            r_rem[k]  <= n_rem;
            r_root[k] <= n_root;
        end
    end

    assign o_valid = r_valid[SQRT_STG-1];
    assign o_side  = r_side[SQRT_STG-1];
    assign o_root  = r_root[SQRT_STG-1];

    // A floor root leaves a remainder of at most twice the root.
    `RMFE_ASSERT_IMPLY(a_rem_bound, r_valid[SQRT_STG-1],
        r_rem[SQRT_STG-1] <= SUM_W'({r_root[SQRT_STG-1], 1'b0}), "sqrt remainder too large")
    `RMFE_ASSERT_IMPLY(a_zero_root, r_valid[SQRT_STG-1] && (r_root[SQRT_STG-1] == '0),
        r_rem[SQRT_STG-1] == '0, "zero root with nonzero radicand")
    `RMFE_ASSERT_IMPLY(a_valid_origin, r_valid[SQRT_STG-1],
        $past(i_valid, SQRT_STG), "sqrt output without matching input")

endmodule

`default_nettype wire

// ===== hdl/room_mode_frequency_evaluator_unit.sv =====
// Top level of the room mode frequency evaluator: configuration registers,
// product and sum-of-squares stages, square root pipeline and output register.
// Depends on rmfe_pkg, rmfe_square, rmfe_isqrt and the assertion macro header.
//
// One mode order triple is taken per clock whenever i_start is high and o_busy
// is low; o_busy is high while reset is applied and until the first clock edge
// after reset is released. Each result appears on the output ports with o_valid
// high for exactly one cycle, in start order; the receiver cannot hold results
// off, so it must take every transfer as it comes. The pipeline is made up of
// the square root pipeline, which resolves one of the 35 root bits per stage,
// plus four stages for the order*step products, the 17x17 partial products,
// square assembly and the sum of squares, and one output register. Write the
// configuration registers only while no item is in flight.
`default_nettype none

`include "room_mode_frequency_evaluator_unit_defines.svh"

module room_mode_frequency_evaluator_unit
    import rmfe_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_start,
    output logic                       o_busy,
    input  wire logic [ORDER_W-1:0]    i_order_x,
    input  wire logic [ORDER_W-1:0]    i_order_y,
    input  wire logic [ORDER_W-1:0]    i_order_z,
    output logic                       o_valid,
    output logic      [FREQ_W-1:0]     o_mode_freq,
    output logic      [KIND_W-1:0]     o_mode_kind,
    output logic                       o_in_band
);

    logic [STEP_W-1:0] r_step_x;
    logic [STEP_W-1:0] r_step_y;
    logic [STEP_W-1:0] r_step_z;
    logic [FREQ_W-1:0] r_band_limit;
    logic              r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_x     <= '0;
            r_step_y     <= '0;
            r_step_z     <= '0;
            r_band_limit <= '0;
            r_busy       <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_STEP_X:     r_step_x     <= i_cfg_data[STEP_W-1:0];
                    CFG_STEP_Y:     r_step_y     <= i_cfg_data[STEP_W-1:0];
                    CFG_STEP_Z:     r_step_z     <= i_cfg_data[STEP_W-1:0];
                    CFG_BAND_LIMIT: r_band_limit <= i_cfg_data[FREQ_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    assign o_busy = r_busy;

    // Stage 1: per-axis products, mode kind and order range check.
    logic              w_accept;
    logic              w_steps_ok;
    logic [PROD_W-1:0] n_px;
    logic [PROD_W-1:0] n_py;
    logic [PROD_W-1:0] n_pz;
    t_side             n_s1_side;
    logic              r_s1_valid;
    t_side             r_s1_side;
    logic [PROD_W-1:0] r_s1_px;
    logic [PROD_W-1:0] r_s1_py;
    logic [PROD_W-1:0] r_s1_pz;

    assign w_accept   = i_start && !r_busy;
    assign w_steps_ok = (r_step_x != '0) && (r_step_y != '0) && (r_step_z != '0);

    // A zero step invalidates the room: zeroed products give frequency zero.
    assign n_px = w_steps_ok ? (PROD_W'(i_order_x) * PROD_W'(r_step_x)) : '0;
    assign n_py = w_steps_ok ? (PROD_W'(i_order_y) * PROD_W'(r_step_y)) : '0;
    assign n_pz = w_steps_ok ? (PROD_W'(i_order_z) * PROD_W'(r_step_z)) : '0;

    assign n_s1_side.kind = KIND_W'(i_order_x != '0) + KIND_W'(i_order_y != '0)
                          + KIND_W'(i_order_z != '0);
    assign n_s1_side.order_ok = (i_order_x <= ORDER_MAX) && (i_order_y <= ORDER_MAX)
                              && (i_order_z <= ORDER_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
        r_s1_side <= n_s1_side;
        r_s1_px   <= n_px;
        r_s1_py   <= n_py;
        r_s1_pz   <= n_pz;
    end

    // Stages 2 and 3: squares of the products.
    logic [SQ_W-1:0] w_sq_x;
    logic [SQ_W-1:0] w_sq_y;
    logic [SQ_W-1:0] w_sq_z;
    logic            r_s2_valid;
    t_side           r_s2_side;
    logic            r_s3_valid;
    t_side           r_s3_side;

    rmfe_square u_square_x (.i_clk(i_clk), .i_val(r_s1_px), .o_sq(w_sq_x));
    rmfe_square u_square_y (.i_clk(i_clk), .i_val(r_s1_py), .o_sq(w_sq_y));
    rmfe_square u_square_z (.i_clk(i_clk), .i_val(r_s1_pz), .o_sq(w_sq_z));

    // Stage 4: sum of the three squares.
    logic [SUM_W-1:0] n_sum;
    logic             r_s4_valid;
    t_side            r_s4_side;
    logic [SUM_W-1:0] r_s4_sum;

    assign n_sum = SUM_W'(w_sq_x) + SUM_W'(w_sq_y) + SUM_W'(w_sq_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
        r_s2_side <= r_s1_side;
        r_s3_side <= r_s2_side;
        r_s4_side <= r_s3_side;
        r_s4_sum  <= n_sum;
    end

    // Square root pipeline.
    logic              w_rt_valid;
    t_side             w_rt_side;
    logic [ROOT_W-1:0] w_root;

    rmfe_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s4_valid),
        .i_side  (r_s4_side),
        .i_rad   (r_s4_sum),
        .o_valid (w_rt_valid),
        .o_side  (w_rt_side),
        .o_root  (w_root)
    );

    // Output stage: band check on the full root, then saturation.
    logic              n_band;
    logic [FREQ_W-1:0] n_freq;
    logic              r_out_valid;
    logic [FREQ_W-1:0] r_freq;
    logic [KIND_W-1:0] r_kind;
    logic              r_band;

    assign n_band = (w_root != '0) && (w_root <= ROOT_W'(r_band_limit))
                  && w_rt_side.order_ok;
    assign n_freq = w_root[ROOT_W-1] ? {FREQ_W{1'b1}} : w_root[FREQ_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_rt_valid;
        end
        r_freq <= n_freq;
        r_kind <= w_rt_side.kind;
        r_band <= n_band;
    end

    assign o_valid     = r_out_valid;
    assign o_mode_freq = r_freq;
    assign o_mode_kind = r_kind;
    assign o_in_band   = r_band;

    `RMFE_ASSERT_DELAY(a_latency, i_start && !o_busy, PIPE_LAT, o_valid,
        "result missing after pipeline latency")
    `RMFE_ASSERT_IMPLY(a_band_nonzero, o_valid && o_in_band, o_mode_freq != '0,
        "in-band flag on zero frequency")
    `RMFE_ASSERT_IMPLY(a_no_mode, o_valid && (o_mode_kind == '0),
        (o_mode_freq == '0) && !o_in_band, "all-zero orders gave a frequency")

endmodule

`default_nettype wire
